// ===== rtl/core/rbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and constants for the rANS byte encoder.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int unsigned StateW   = 32;
  localparam int unsigned FreqW    = 13;
  localparam int unsigned ScaleLog = 12;
  localparam logic [StateW-1:0] LowerBound = 32'h0080_0000;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2,
    FUNC_BAD    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_RENORM = 2'd0,
    KIND_FINAL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/rbe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_in_if / rbe_out_if
// Valid/ready channels carrying the input and result beats.
// ----------------------------------------------------------------------------
interface rbe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  symbol;
  logic [12:0] frequency;
  modport source (output valid, func, symbol, frequency, input ready);
  modport sink (input valid, func, symbol, frequency, output ready);
endinterface

interface rbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;
  modport source (output valid, out_byte, kind, last, input ready);
  modport sink (input valid, out_byte, kind, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rbe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbe_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read first: a write returns the old entry, read registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rans_byte_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rans_byte_encoder_unit
// Static order-0 rANS byte encoder with a table memory and serial divider.
// ----------------------------------------------------------------------------
// One item at a time. A load is a single table write. An
// encode reads the frequency/cumulative memory and checks the entry,
// passes through the renormalization step, which emits at most two
// bytes, then runs a restoring divider that retires one quotient bit per
// cycle and forms the new state. A flush emits four beats, one per cycle
// while the output is ready. The divider loop sets the encode rate.
// The table memory needs no clearing pass.
module rans_byte_encoder_unit
  import rbe_pkg::*;
#(
  parameter int unsigned Alphabet = 256
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rbe_in_if.sink   in_i,
  rbe_out_if.source out_o
);

  localparam int unsigned AddrW = (Alphabet > 1) ? $clog2(Alphabet) : 1;
  localparam int unsigned EntW  = 2 * FreqW;
  localparam logic [FreqW:0] ScaleTotal = (FreqW+1)'(1) << ScaleLog;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_CHK  = 7'b0000100,
    ST_REN  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [StateW-1:0] x_q, x_d;
  logic [FreqW-1:0] sum_q, sum_d;
  logic [AddrW-1:0] sym_q, sym_d;
  logic [5:0] cnt_q, cnt_d;
  logic [StateW-1:0] quo_q, quo_d;
  logic [FreqW:0] rem_q, rem_d;
  logic [1:0] flushing_q, flushing_d;
  logic out_valid_q, out_valid_d;
  result_t res_q, res_d;

  // Table memory: {freq, cum} per symbol.
  logic ram_we;
  logic [EntW-1:0] ram_wdata, ram_rdata;
  logic [AddrW-1:0] ram_addr;
  logic [FreqW-1:0] rd_freq, rd_cum;

  rbe_ram #(.Width(EntW), .Depth(Alphabet)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rd_freq = ram_rdata[EntW-1:FreqW];
  assign rd_cum  = ram_rdata[FreqW-1:0];

  logic sym_ok, accept, out_free;
  logic [FreqW-1:0] base;
  logic [FreqW:0] load_sum;
  logic [StateW+FreqW-1:0] limit;
  logic [FreqW:0] rem_sh;
  logic [FreqW:0] rem_sub;

  assign sym_ok   = ({24'd0, in_i.symbol} < 32'(Alphabet));
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;
  assign base     = (in_i.symbol == 8'd0) ? '0 : sum_q;
  assign load_sum = {1'b0, base} + {1'b0, in_i.frequency};
  assign limit    = (StateW+FreqW)'(rd_freq) << (StateW - 1 - ScaleLog);
  assign rem_sh   = {rem_q[FreqW-1:0], x_q[StateW-1]};
  assign rem_sub  = rem_sh - {1'b0, rd_freq};

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = res_q.out_byte;
  assign out_o.kind     = res_q.kind;
  assign out_o.last     = res_q.last;

  // Control and datapath sequencing.
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    sum_d       = sum_q;
    sym_d       = sym_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    flushing_d  = flushing_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_addr    = sym_q;
    ram_wdata   = {in_i.frequency[FreqW-1:0], base};
    unique case (state_q)
      ST_IDLE: begin
        ram_addr = in_i.symbol[AddrW-1:0];
        if (accept) begin
          sym_d = in_i.symbol[AddrW-1:0];
          case (in_i.func)
            FUNC_LOAD: begin
              if (!sym_ok || load_sum > ScaleTotal) begin
                out_valid_d = 1'b1;
                res_d = '{8'd0, KIND_ERROR, 1'b1};
              end else begin
                ram_we = 1'b1;
                sum_d  = load_sum[FreqW-1:0];
              end
            end
            FUNC_ENCODE: begin
              if (!sym_ok) begin
                out_valid_d = 1'b1;
                res_d = '{8'd0, KIND_ERROR, 1'b1};
              end else begin
                state_d = ST_READ;
              end
            end
            FUNC_FLUSH: begin
              flushing_d = 2'd0;
              state_d = ST_OUT;
            end
            default: begin
              out_valid_d = 1'b1;
              res_d = '{8'd0, KIND_ERROR, 1'b1};
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (rd_freq == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            res_d = '{8'd0, KIND_ERROR, 1'b1};
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_REN;
        end
      end
      ST_REN: begin
        // Emit a byte while the state is at or above the limit.
        if ({{FreqW{1'b0}}, x_q} >= limit) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            res_d.out_byte = x_q[7:0];
            res_d.kind = KIND_RENORM;
            res_d.last = ({{FreqW+8{1'b0}}, x_q[StateW-1:8]} < limit);
            x_d = {8'd0, x_q[StateW-1:8]};
          end
        end else begin
          cnt_d = '0;
          rem_d = '0;
          quo_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        x_d = {x_q[StateW-2:0], 1'b0};
        if (!rem_sub[FreqW]) begin
          rem_d = rem_sub;
          quo_d = {quo_q[StateW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[StateW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        x_d = (quo_q << ScaleLog) + StateW'(rem_q) + StateW'(rd_cum);
        state_d = ST_IDLE;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d.out_byte = x_q[8*flushing_q +: 8];
          res_d.kind = KIND_FINAL;
          res_d.last = (flushing_q == 2'd3);
          flushing_d = flushing_q + 2'd1;
          if (flushing_q == 2'd3) begin
            x_d = LowerBound;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= LowerBound;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      flushing_q  <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      flushing_q  <= flushing_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

endmodule
`default_nettype wire
